@@ hdl/cam_pkg.sv @@
// Package with the types, tables and round functions shared by the Camellia core.
`default_nettype none
package cam_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEYGEN,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH
    } state_t;

    // Configuration register indexes.
    localparam logic [2:0] CfgKeySize = 3'd0;
    localparam logic [2:0] CfgKey0    = 3'd1;
    localparam logic [2:0] CfgKey1    = 3'd2;
    localparam logic [2:0] CfgKey2    = 3'd3;
    localparam logic [2:0] CfgKey3    = 3'd4;

    // Key size codes.
    localparam logic [1:0] KeySize128 = 2'd0;
    localparam logic [1:0] KeySize192 = 2'd1;

    // Commands.
    localparam logic CmdEncrypt = 1'b0;
    localparam logic CmdDecrypt = 1'b1;

    // Subkey slot layout.
    localparam logic [5:0] SlotKw = 6'd0;
    localparam logic [5:0] SlotKe = 6'd4;
    localparam logic [5:0] SlotK  = 6'd10;
    localparam int         SlotCount = 34;

    // Key sources for the subkey tables.
    localparam logic [1:0] SrcKl = 2'd0;
    localparam logic [1:0] SrcKr = 2'd1;
    localparam logic [1:0] SrcKa = 2'd2;
    localparam logic [1:0] SrcKb = 2'd3;

    localparam logic [63:0] SIGMA [6] = '{
        64'hA09E667F3BCC908B, 64'hB67AE8584CAA73B2, 64'hC6EF372FE94F82BE,
        64'h54FF53A5F1D36F1C, 64'h10E527FADE682D1D, 64'hB05688C2B3E6C1FD
    };

    localparam logic [7:0] SBOX1 [256] = '{
        8'd112,8'd130,8'd44,8'd236,8'd179,8'd39,8'd192,8'd229,
        8'd228,8'd133,8'd87,8'd53,8'd234,8'd12,8'd174,8'd65,
        8'd35,8'd239,8'd107,8'd147,8'd69,8'd25,8'd165,8'd33,
        8'd237,8'd14,8'd79,8'd78,8'd29,8'd101,8'd146,8'd189,
        8'd134,8'd184,8'd175,8'd143,8'd124,8'd235,8'd31,8'd206,
        8'd62,8'd48,8'd220,8'd95,8'd94,8'd197,8'd11,8'd26,
        8'd166,8'd225,8'd57,8'd202,8'd213,8'd71,8'd93,8'd61,
        8'd217,8'd1,8'd90,8'd214,8'd81,8'd86,8'd108,8'd77,
        8'd139,8'd13,8'd154,8'd102,8'd251,8'd204,8'd176,8'd45,
        8'd116,8'd18,8'd43,8'd32,8'd240,8'd177,8'd132,8'd153,
        8'd223,8'd76,8'd203,8'd194,8'd52,8'd126,8'd118,8'd5,
        8'd109,8'd183,8'd169,8'd49,8'd209,8'd23,8'd4,8'd215,
        8'd20,8'd88,8'd58,8'd97,8'd222,8'd27,8'd17,8'd28,
        8'd50,8'd15,8'd156,8'd22,8'd83,8'd24,8'd242,8'd34,
        8'd254,8'd68,8'd207,8'd178,8'd195,8'd181,8'd122,8'd145,
        8'd36,8'd8,8'd232,8'd168,8'd96,8'd252,8'd105,8'd80,
        8'd170,8'd208,8'd160,8'd125,8'd161,8'd137,8'd98,8'd151,
        8'd84,8'd91,8'd30,8'd149,8'd224,8'd255,8'd100,8'd210,
        8'd16,8'd196,8'd0,8'd72,8'd163,8'd247,8'd117,8'd219,
        8'd138,8'd3,8'd230,8'd218,8'd9,8'd63,8'd221,8'd148,
        8'd135,8'd92,8'd131,8'd2,8'd205,8'd74,8'd144,8'd51,
        8'd115,8'd103,8'd246,8'd243,8'd157,8'd127,8'd191,8'd226,
        8'd82,8'd155,8'd216,8'd38,8'd200,8'd55,8'd198,8'd59,
        8'd129,8'd150,8'd111,8'd75,8'd19,8'd190,8'd99,8'd46,
        8'd233,8'd121,8'd167,8'd140,8'd159,8'd110,8'd188,8'd142,
        8'd41,8'd245,8'd249,8'd182,8'd47,8'd253,8'd180,8'd89,
        8'd120,8'd152,8'd6,8'd106,8'd231,8'd70,8'd113,8'd186,
        8'd212,8'd37,8'd171,8'd66,8'd136,8'd162,8'd141,8'd250,
        8'd114,8'd7,8'd185,8'd85,8'd248,8'd238,8'd172,8'd10,
        8'd54,8'd73,8'd42,8'd104,8'd60,8'd56,8'd241,8'd164,
        8'd64,8'd40,8'd211,8'd123,8'd187,8'd201,8'd67,8'd193,
        8'd21,8'd227,8'd173,8'd244,8'd119,8'd199,8'd128,8'd158
    };

    // Subkey tables for a 128-bit key: source and left rotation per slot; HI_S gives the half for every key size.
    localparam logic [1:0] SRC_S [SlotCount] = '{
        SrcKl, SrcKl, SrcKa, SrcKa, SrcKa, SrcKa, SrcKl, SrcKl, SrcKl, SrcKl,
        SrcKa, SrcKa, SrcKl, SrcKl, SrcKa, SrcKa, SrcKl, SrcKl, SrcKa, SrcKl,
        SrcKa, SrcKa, SrcKl, SrcKl, SrcKa, SrcKa, SrcKl, SrcKl,
        SrcKl, SrcKl, SrcKl, SrcKl, SrcKl, SrcKl
    };
    localparam logic [6:0] ROT_S [SlotCount] = '{
        7'd0, 7'd0, 7'd111, 7'd111, 7'd30, 7'd30, 7'd77, 7'd77, 7'd0, 7'd0,
        7'd0, 7'd0, 7'd15, 7'd15, 7'd15, 7'd15, 7'd45, 7'd45, 7'd45, 7'd60,
        7'd60, 7'd60, 7'd94, 7'd94, 7'd94, 7'd94, 7'd111, 7'd111,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
    };
    localparam logic HI_S [SlotCount] = '{
        1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
        1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
        1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
        1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0
    };

    // Subkey tables for 192 and 256-bit keys.
    localparam logic [1:0] SRC_L [SlotCount] = '{
        SrcKl, SrcKl, SrcKb, SrcKb, SrcKr, SrcKr, SrcKl, SrcKl, SrcKa, SrcKa,
        SrcKb, SrcKb, SrcKr, SrcKr, SrcKa, SrcKa, SrcKb, SrcKb, SrcKl, SrcKl,
        SrcKa, SrcKa, SrcKr, SrcKr, SrcKb, SrcKb, SrcKl, SrcKl,
        SrcKr, SrcKr, SrcKa, SrcKa, SrcKl, SrcKl
    };
    localparam logic [6:0] ROT_L [SlotCount] = '{
        7'd0, 7'd0, 7'd111, 7'd111, 7'd30, 7'd30, 7'd60, 7'd60, 7'd77, 7'd77,
        7'd0, 7'd0, 7'd15, 7'd15, 7'd15, 7'd15, 7'd30, 7'd30, 7'd45, 7'd45,
        7'd45, 7'd45, 7'd60, 7'd60, 7'd60, 7'd60, 7'd77, 7'd77,
        7'd94, 7'd94, 7'd94, 7'd94, 7'd111, 7'd111
    };

    // Rotate a 128-bit value left by one of the schedule's fixed amounts.
    function automatic logic [127:0] rotl128(input logic [127:0] x, input logic [6:0] n);
        logic [127:0] r;
        case (n)
            7'd15:   r = {x[112:0], x[127:113]};
            7'd30:   r = {x[97:0], x[127:98]};
            7'd45:   r = {x[82:0], x[127:83]};
            7'd60:   r = {x[67:0], x[127:68]};
            7'd77:   r = {x[50:0], x[127:51]};
            7'd94:   r = {x[33:0], x[127:34]};
            7'd111:  r = {x[16:0], x[127:17]};
            default: r = x;
        endcase
        return r;
    endfunction

    // Look up one 64-bit subkey from the key material.
    function automatic logic [63:0] subkey(input logic [5:0] slot, input logic long_key,
                                           input logic [127:0] kl, input logic [127:0] kr,
                                           input logic [127:0] ka, input logic [127:0] kb);
        logic [1:0]   src;
        logic [6:0]   rot;
        logic         hi;
        logic [127:0] s;
        logic [127:0] r;
        src = long_key ? SRC_L[slot] : SRC_S[slot];
        rot = long_key ? ROT_L[slot] : ROT_S[slot];
        hi  = HI_S[slot];
        case (src)
            SrcKl:   s = kl;
            SrcKr:   s = kr;
            SrcKa:   s = ka;
            default: s = kb;
        endcase
        r = rotl128(s, rot);
        return hi ? r[127:64] : r[63:0];
    endfunction

    // The F function: key mix, S-boxes and the P byte mixing.
    function automatic logic [63:0] feistel(input logic [63:0] din, input logic [63:0] key);
        logic [63:0] x;
        logic [7:0]  t [8];
        logic [7:0]  u [8];
        logic [7:0]  s;
        x = din ^ key;
        for (int i = 0; i < 8; i++) begin
            t[i] = x[63 - 8 * i -: 8];
        end
        u[0] = SBOX1[t[0]];
        s    = SBOX1[t[1]];
        u[1] = {s[6:0], s[7]};
        s    = SBOX1[t[2]];
        u[2] = {s[0], s[7:1]};
        u[3] = SBOX1[{t[3][6:0], t[3][7]}];
        s    = SBOX1[t[4]];
        u[4] = {s[6:0], s[7]};
        s    = SBOX1[t[5]];
        u[5] = {s[0], s[7:1]};
        u[6] = SBOX1[{t[6][6:0], t[6][7]}];
        u[7] = SBOX1[t[7]];
        return {u[0] ^ u[2] ^ u[3] ^ u[5] ^ u[6] ^ u[7],
                u[0] ^ u[1] ^ u[3] ^ u[4] ^ u[6] ^ u[7],
                u[0] ^ u[1] ^ u[2] ^ u[4] ^ u[5] ^ u[7],
                u[1] ^ u[2] ^ u[3] ^ u[4] ^ u[5] ^ u[6],
                u[0] ^ u[1] ^ u[5] ^ u[6] ^ u[7],
                u[1] ^ u[2] ^ u[4] ^ u[6] ^ u[7],
                u[2] ^ u[3] ^ u[4] ^ u[5] ^ u[7],
                u[0] ^ u[3] ^ u[4] ^ u[5] ^ u[6]};
    endfunction

    // FL layer function.
    function automatic logic [63:0] fl(input logic [63:0] din, input logic [63:0] key);
        logic [31:0] x1;
        logic [31:0] x2;
        logic [31:0] a;
        x1 = din[63:32];
        x2 = din[31:0];
        a  = x1 & key[63:32];
        x2 = x2 ^ {a[30:0], a[31]};
        x1 = x1 ^ (x2 | key[31:0]);
        return {x1, x2};
    endfunction

    // Inverse FL layer function.
    function automatic logic [63:0] fl_inv(input logic [63:0] din, input logic [63:0] key);
        logic [31:0] y1;
        logic [31:0] y2;
        logic [31:0] a;
        y1 = din[63:32];
        y2 = din[31:0];
        y1 = y1 ^ (y2 | key[31:0]);
        a  = y1 & key[63:32];
        y2 = y2 ^ {a[30:0], a[31]};
        return {y1, y2};
    endfunction

endpackage
`default_nettype wire

@@ hdl/camellia_block_cipher_core.sv @@
// Camellia block cipher core with an iterative round unit and on-demand key schedule.
//
// Usage:
// The key and key size are written over the configuration port (cfg_we, cfg_index,
// cfg_data) while the core is idle. Any key write marks the key schedule stale.
// An input transfer (in_valid high, in_stall low) carries one 128-bit block and a
// command: encrypt or decrypt. in_stall is high from that transfer until the block
// has been moved into the output register.
// One shared F/FL unit does one F-round or one FL layer pair per cycle. A block
// goes through input whitening, the F-rounds with FL layer pairs between the round
// groups, and output whitening into the output register.
// A new block is taken only once the previous one is in the output register.
// The first block after a key write first derives KA and, for the longer keys,
// then KB through the same F unit.
// The result is held in an output register with out_valid until the output
// transfer; if the receiver stalls, the finished block waits in the core and no
// new block is taken.
// Reset clears the key registers to a 128-bit all-zero key, marks the schedule
// stale and empties the output register.
`default_nettype none
module camellia_block_cipher_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic [63:0] block_high,
    input  wire logic [63:0] block_low,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      result_high,
    output logic [63:0]      result_low
);
    import cam_pkg::*;

    state_t       state_reg, state_next;
    logic         ready_reg, ready_next;
    logic         out_valid_reg, out_valid_next;
    logic [1:0]   key_size_reg;
    logic [63:0]  key0_reg, key1_reg, key2_reg, key3_reg;
    logic [127:0] ka_reg, ka_next;
    logic [127:0] kb_reg, kb_next;
    logic [63:0]  d1_reg, d1_next;
    logic [63:0]  d2_reg, d2_next;
    logic         cmd_reg, cmd_next;
    logic [63:0]  blk_h_reg, blk_h_next;
    logic [63:0]  blk_l_reg, blk_l_next;
    logic [2:0]   pos_reg, pos_next;
    logic [1:0]   grp_reg, grp_next;
    logic [63:0]  res_h_reg, res_h_next;
    logic [63:0]  res_l_reg, res_l_next;

    logic         long_key;
    logic [1:0]   grp_last;
    logic [127:0] kl;
    logic [127:0] kr;
    logic [4:0]   j_enc;
    logic [4:0]   j_sel;
    logic [1:0]   layer;
    logic [5:0]   slot_a;
    logic [5:0]   slot_b;
    logic [63:0]  sk_a;
    logic [63:0]  sk_b;
    logic [63:0]  f_in;
    logic [63:0]  f_key;
    logic [63:0]  f_out;
    logic [63:0]  d1_f;

    // Key material derived from configuration.
    assign long_key = (key_size_reg != KeySize128);
    assign grp_last = long_key ? 2'd3 : 2'd2;
    assign kl       = {key0_reg, key1_reg};
    assign kr       = (key_size_reg == KeySize128) ? 128'd0 :
                      (key_size_reg == KeySize192) ? {key2_reg, ~key2_reg} :
                                                     {key2_reg, key3_reg};

    // Round index and FL layer index for the current step.
    assign j_enc = 5'(grp_reg) * 5'd6 + 5'(pos_reg);
    assign j_sel = (cmd_reg == CmdDecrypt) ? ((long_key ? 5'd23 : 5'd17) - j_enc) : j_enc;
    assign layer = (cmd_reg == CmdDecrypt) ? (grp_last - 2'd1 - grp_reg) : grp_reg;

    // Subkey slot selection for the shared unit.
    always_comb
    begin
        slot_a = SlotK + 6'(j_sel);
        slot_b = SlotKe + {3'd0, layer, 1'b1};
        case (state_reg)
            ST_LOAD:
            begin
                slot_a = (cmd_reg == CmdDecrypt) ? SlotKw + 6'd2 : SlotKw;
                slot_b = (cmd_reg == CmdDecrypt) ? SlotKw + 6'd3 : SlotKw + 6'd1;
            end
            ST_FINISH:
            begin
                slot_a = (cmd_reg == CmdDecrypt) ? SlotKw : SlotKw + 6'd2;
                slot_b = (cmd_reg == CmdDecrypt) ? SlotKw + 6'd1 : SlotKw + 6'd3;
            end
            ST_ROUND:
            begin
                if (pos_reg == 3'd6) begin
                    if (cmd_reg == CmdDecrypt) begin
                        slot_a = SlotKe + {3'd0, layer, 1'b1};
                        slot_b = SlotKe + {3'd0, layer, 1'b0};
                    end else begin
                        slot_a = SlotKe + {3'd0, layer, 1'b0};
                        slot_b = SlotKe + {3'd0, layer, 1'b1};
                    end
                end
            end
            default:
            begin
                slot_a = SlotKw;
                slot_b = SlotKw;
            end
        endcase
    end

    assign sk_a = subkey(slot_a, long_key, kl, kr, ka_reg, kb_reg);
    assign sk_b = subkey(slot_b, long_key, kl, kr, ka_reg, kb_reg);

    // Shared F unit: used for key derivation and for the cipher rounds.
    always_comb
    begin
        if (state_reg == ST_KEYGEN) begin
            f_in  = pos_reg[0] ? d2_reg : d1_reg;
            f_key = SIGMA[pos_reg];
        end else begin
            f_in  = pos_reg[0] ? d2_reg : d1_reg;
            f_key = sk_a;
        end
    end

    assign f_out = feistel(f_in, f_key);
    assign d1_f  = d1_reg ^ f_out;

    // Sequencer: next state and datapath.
    always_comb
    begin
        state_next     = state_reg;
        ready_next     = ready_reg;
        out_valid_next = out_valid_reg && out_stall;
        ka_next        = ka_reg;
        kb_next        = kb_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        cmd_next       = cmd_reg;
        blk_h_next     = blk_h_reg;
        blk_l_next     = blk_l_reg;
        pos_next       = pos_reg;
        grp_next       = grp_reg;
        res_h_next     = res_h_reg;
        res_l_next     = res_l_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd_next   = command;
                    blk_h_next = block_high;
                    blk_l_next = block_low;
                    pos_next   = 3'd0;
                    if (ready_reg) begin
                        state_next = ST_LOAD;
                    end else begin
                        d1_next    = kl[127:64] ^ kr[127:64];
                        d2_next    = kl[63:0] ^ kr[63:0];
                        state_next = ST_KEYGEN;
                    end
                end
            end
            ST_KEYGEN:
            begin
                pos_next = pos_reg + 3'd1;
                if (!pos_reg[0]) begin
                    d2_next = d2_reg ^ f_out;
                end else if (pos_reg == 3'd1) begin
                    d1_next = d1_f ^ kl[127:64];
                    d2_next = d2_reg ^ kl[63:0];
                end else if (pos_reg == 3'd3) begin
                    ka_next = {d1_f, d2_reg};
                    d1_next = d1_f ^ kr[127:64];
                    d2_next = d2_reg ^ kr[63:0];
                    if (!long_key) begin
                        ready_next = 1'b1;
                        state_next = ST_LOAD;
                    end
                end else begin
                    kb_next    = {d1_f, d2_reg};
                    ready_next = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                d1_next    = blk_h_reg ^ sk_a;
                d2_next    = blk_l_reg ^ sk_b;
                pos_next   = 3'd0;
                grp_next   = 2'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (pos_reg == 3'd6) begin
                    d1_next  = fl(d1_reg, sk_a);
                    d2_next  = fl_inv(d2_reg, sk_b);
                    pos_next = 3'd0;
                    grp_next = grp_reg + 2'd1;
                end else begin
                    if (pos_reg[0]) begin
                        d1_next = d1_f;
                    end else begin
                        d2_next = d2_reg ^ f_out;
                    end
                    pos_next = pos_reg + 3'd1;
                    if (pos_reg == 3'd5 && grp_reg == grp_last) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall) begin
                    res_h_next     = d2_reg ^ sk_a;
                    res_l_next     = d1_reg ^ sk_b;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // Any key write makes the stored schedule stale.
        if (cfg_we && cfg_index <= CfgKey3) begin
            ready_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_size_reg <= KeySize128;
            key0_reg     <= '0;
            key1_reg     <= '0;
            key2_reg     <= '0;
            key3_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CfgKeySize: key_size_reg <= cfg_data[1:0];
                CfgKey0:    key0_reg     <= cfg_data;
                CfgKey1:    key1_reg     <= cfg_data;
                CfgKey2:    key2_reg     <= cfg_data;
                CfgKey3:    key3_reg     <= cfg_data;
                default:    key_size_reg <= key_size_reg;
            endcase
        end
    end

    // Datapath and derived key registers.
    always_ff @(posedge clk)
    begin
        ka_reg    <= ka_next;
        kb_reg    <= kb_next;
        d1_reg    <= d1_next;
        d2_reg    <= d2_next;
        cmd_reg   <= cmd_next;
        blk_h_reg <= blk_h_next;
        blk_l_reg <= blk_l_next;
        pos_reg   <= pos_next;
        grp_reg   <= grp_next;
        res_h_reg <= res_h_next;
        res_l_reg <= res_l_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign result_high = res_h_reg;
    assign result_low  = res_l_reg;

`ifndef SYNTHESIS
    // A block taken with a stale schedule goes through key derivation first.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !ready_reg) |=> (state_reg == ST_KEYGEN))
        else $error("stale schedule not derived");

    // A key write always marks the schedule stale.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index <= CfgKey3) |=> !ready_reg)
        else $error("schedule still marked ready after key write");

    // The round counters stay inside the round plan.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (pos_reg <= 3'd6 && grp_reg <= grp_last))
        else $error("round counter out of range");

    // Leaving the finish state always loads the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && state_next == ST_IDLE) |=> out_valid_reg)
        else $error("finished block not presented");
`endif

endmodule
`default_nettype wire
